@@ rtl/psfd_pkg.sv @@
// ---------------------------------------------------------------------------
// psfd_pkg: shared types and constants of the prefix/suffix frame deframer
// Result kinds, body part tags, frame layout sizes and the result bundle.
// ---------------------------------------------------------------------------
package psfd_pkg;

  // Frame layout
  localparam int unsigned HEADER_BYTES = 18;
  localparam int unsigned IV_BYTES     = 12;
  localparam int unsigned TAG_BYTES    = 16;
  localparam int unsigned SUFFIX_BYTES = 4;

  // Header byte positions of the three big-endian words
  localparam int unsigned SEQ_FIRST = 6;
  localparam int unsigned CMD_FIRST = 10;
  localparam int unsigned LEN_FIRST = 14;

  // Sync prefix 00 00 66 99, element 0 arrives first
  localparam logic [3:0][7:0] SYNC_BYTES = {8'h99, 8'h66, 8'h00, 8'h00};
  localparam logic [31:0]     SUFFIX_WORD = 32'h0000_9966;

  // Limit register
  localparam int unsigned    LIMIT_WIDTH        = 24;
  localparam logic [23:0]    DEFAULT_MAX_LENGTH = 24'h10_0000;

  // Body byte counter width default
  localparam int unsigned COUNT_WIDTH = 24;

  typedef enum logic [2:0] {
    KIND_HEADER     = 3'd0,
    KIND_BODY       = 3'd1,
    KIND_END_OK     = 3'd2,
    KIND_BAD_LENGTH = 3'd3,
    KIND_BAD_SUFFIX = 3'd4
  } result_kind_e;

  typedef enum logic [1:0] {
    PART_IV     = 2'd0,
    PART_CIPHER = 2'd1,
    PART_TAG    = 2'd2
  } body_part_e;

  typedef struct packed {
    result_kind_e kind;
    logic [31:0]  seq;
    logic [31:0]  cmd;
    logic [31:0]  len;
    logic [7:0]   data;
    body_part_e   part;
    logic         last;
  } result_t;

endpackage

@@ rtl/psfd_in_stage.sv @@
// ---------------------------------------------------------------------------
// psfd_in_stage: input register
// Holds one received byte until the parser consumes it.
// ---------------------------------------------------------------------------
module psfd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       item_valid_o,
  output logic [7:0] item_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // Free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;

endmodule

@@ rtl/psfd_core.sv @@
// ---------------------------------------------------------------------------
// psfd_core: frame parser
// Prefix hunt, header capture, length check, body tagging and suffix check.
// ---------------------------------------------------------------------------
module psfd_core #(
  parameter int unsigned CountWidth = psfd_pkg::COUNT_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                byte_i,
  input  logic                      cfg_we_i,
  input  logic [psfd_pkg::LIMIT_WIDTH-1:0] cfg_wdata_i,
  output logic                      emit_o,
  output psfd_pkg::result_t         res_o
);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2,
    PH_SUFFIX = 2'd3
  } phase_e;

  localparam logic [31:0] CntMask  = 32'((33'd1 << CountWidth) - 33'd1);
  localparam logic [4:0]  HdrLast  = 5'(psfd_pkg::HEADER_BYTES - 1);
  localparam logic [4:0]  SfxLast  = 5'(psfd_pkg::SUFFIX_BYTES - 1);
  localparam logic [31:0] MinLen   = 32'(psfd_pkg::IV_BYTES + psfd_pkg::TAG_BYTES);
  localparam logic [4:0]  HdrStart = 5'(4);

  phase_e                 phase_q, phase_d;
  logic [1:0]             match_q, match_d;
  logic [4:0]             hdr_q, hdr_d;
  logic [31:0]            seq_q, seq_d;
  logic [31:0]            cmd_q, cmd_d;
  logic [31:0]            len_q, len_d;
  logic [CountWidth-1:0]  body_q, body_d;
  logic [31:0]            sfx_q, sfx_d;
  logic [psfd_pkg::LIMIT_WIDTH-1:0] max_q;

  logic [2:0]  hunt_m;
  logic [31:0] limit;
  logic [31:0] idx32;
  logic        last;

  // Overlap-aware match count for the sync prefix
  function automatic logic [2:0] hunt_next(input logic [1:0] m, input logic [7:0] b);
    logic [2:0] r;
    if (b == psfd_pkg::SYNC_BYTES[m]) begin
      r = 3'(m) + 3'd1;
    end else if (m == 2'd2 && b == 8'h00) begin
      r = 3'd2;
    end else if (b == 8'h00) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  // Limit saturated to what the body counter can reach
  assign limit = ({8'd0, max_q} > CntMask) ? CntMask : {8'd0, max_q};
  assign idx32 = 32'(body_q);
  assign last  = (33'(body_q) + 33'd1) >= {1'b0, len_q};
  assign hunt_m = hunt_next(match_q, byte_i);

  // Next state and result
  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    hdr_d   = hdr_q;
    seq_d   = seq_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    body_d  = body_q;
    sfx_d   = sfx_q;
    emit_o  = 1'b0;
    res_o.kind = psfd_pkg::KIND_HEADER;
    res_o.data = 8'd0;
    res_o.part = psfd_pkg::PART_IV;
    res_o.last = 1'b0;

    case (phase_q)
      PH_HUNT: begin
        if (hunt_m == 3'd4) begin
          phase_d = PH_HEADER;
          hdr_d   = HdrStart;
          match_d = 2'd0;
        end else begin
          match_d = hunt_m[1:0];
        end
      end

      PH_HEADER: begin
        if (hdr_q >= 5'(psfd_pkg::SEQ_FIRST) && hdr_q < 5'(psfd_pkg::CMD_FIRST)) begin
          seq_d = {seq_q[23:0], byte_i};
        end else if (hdr_q >= 5'(psfd_pkg::CMD_FIRST) &&
                     hdr_q < 5'(psfd_pkg::LEN_FIRST)) begin
          cmd_d = {cmd_q[23:0], byte_i};
        end else if (hdr_q >= 5'(psfd_pkg::LEN_FIRST)) begin
          len_d = {len_q[23:0], byte_i};
        end
        if (hdr_q == HdrLast) begin
          emit_o = 1'b1;
          hdr_d  = 5'd0;
          if (len_d < MinLen || len_d > limit) begin
            phase_d    = PH_HUNT;
            match_d    = 2'd0;
            res_o.kind = psfd_pkg::KIND_BAD_LENGTH;
          end else begin
            phase_d    = PH_BODY;
            body_d     = '0;
            res_o.kind = psfd_pkg::KIND_HEADER;
          end
        end else begin
          hdr_d = hdr_q + 5'd1;
        end
      end

      PH_BODY: begin
        emit_o     = 1'b1;
        res_o.kind = psfd_pkg::KIND_BODY;
        res_o.data = byte_i;
        res_o.last = last;
        if (idx32 < 32'(psfd_pkg::IV_BYTES)) begin
          res_o.part = psfd_pkg::PART_IV;
        end else if (idx32 >= len_q - 32'(psfd_pkg::TAG_BYTES)) begin
          res_o.part = psfd_pkg::PART_TAG;
        end else begin
          res_o.part = psfd_pkg::PART_CIPHER;
        end
        body_d = body_q + CountWidth'(1);
        if (last) begin
          phase_d = PH_SUFFIX;
          hdr_d   = 5'd0;
          sfx_d   = 32'd0;
        end
      end

      PH_SUFFIX: begin
        sfx_d = {sfx_q[23:0], byte_i};
        if (hdr_q == SfxLast) begin
          emit_o     = 1'b1;
          hdr_d      = 5'd0;
          phase_d    = PH_HUNT;
          match_d    = 2'd0;
          res_o.kind = (sfx_d == psfd_pkg::SUFFIX_WORD) ? psfd_pkg::KIND_END_OK
                                                          : psfd_pkg::KIND_BAD_SUFFIX;
        end else begin
          hdr_d = hdr_q + 5'd1;
        end
      end

      default: begin
        phase_d = PH_HUNT;
      end
    endcase

    // Held header words after this byte's update
    res_o.seq = seq_d;
    res_o.cmd = cmd_d;
    res_o.len = len_d;
  end

  // Parser state and limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      match_q <= 2'd0;
      hdr_q   <= 5'd0;
      seq_q   <= 32'd0;
      cmd_q   <= 32'd0;
      len_q   <= 32'd0;
      body_q  <= '0;
      sfx_q   <= 32'd0;
      max_q   <= psfd_pkg::DEFAULT_MAX_LENGTH;
    end else begin
      if (step_i) begin
        phase_q <= phase_d;
        match_q <= match_d;
        hdr_q   <= hdr_d;
        seq_q   <= seq_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        body_q  <= body_d;
        sfx_q   <= sfx_d;
      end
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ rtl/psfd_out_stage.sv @@
// ---------------------------------------------------------------------------
// psfd_out_stage: result register
// Holds one result item until the consumer takes it.
// ---------------------------------------------------------------------------
module psfd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  psfd_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              free_o,
  output logic              out_valid_o,
  output psfd_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  psfd_pkg::result_t res_q;

  // Room for a new result when empty or draining now
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/prefix_sync_frame_deframer.sv @@
// ---------------------------------------------------------------------------
// prefix_sync_frame_deframer: byte-serial prefix/suffix frame deframer
// Finds the 00 00 66 99 prefix, reports the header, tags body bytes and
// checks the 0x00009966 suffix.
//
//   channel   | handshake              | payload
//   ----------+------------------------+-------------------------------------
//   input     | in_valid_i/in_ready_o  | rx_byte_i
//   result    | out_valid_o/out_ready_i| result_kind_o .. last_body_o
//   config    | cfg_we_i (no wait)     | cfg_wdata_i (max frame length)
//
// One item per cycle sustained while results are taken; the parser updates its state with each item.
// A result passes from its input item through the input register, then the
// result register.
// Reset clears the parser to prefix hunting and the limit to 1048576.
// A stalled result holds in the result register; the input register keeps
// taking bytes that produce no result, and backs up otherwise.
// ---------------------------------------------------------------------------
module prefix_sync_frame_deframer #(
  parameter int unsigned CountWidth = psfd_pkg::COUNT_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [31:0] seq_number_o,
  output logic [31:0] command_code_o,
  output logic [31:0] frame_length_o,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  body_part_o,
  output logic        last_body_o,
  input  logic        cfg_we_i,
  input  logic [psfd_pkg::LIMIT_WIDTH-1:0] cfg_wdata_i
);

  logic              item_valid;
  logic [7:0]        item_byte;
  logic              emit;
  logic              out_free;
  logic              advance;
  logic              load;
  psfd_pkg::result_t core_res;
  psfd_pkg::result_t out_res;

  // An item moves on if it yields nothing or the result register has room
  assign advance = item_valid && (!emit || out_free);
  assign load    = advance && emit;

  psfd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_byte_o  (item_byte)
  );

  psfd_core #(
    .CountWidth (CountWidth)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (item_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .emit_o      (emit),
    .res_o       (core_res)
  );

  psfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (core_res),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign result_kind_o  = out_res.kind;
  assign seq_number_o   = out_res.seq;
  assign command_code_o = out_res.cmd;
  assign frame_length_o = out_res.len;
  assign data_byte_o    = out_res.data;
  assign body_part_o    = out_res.part;
  assign last_body_o    = out_res.last;

endmodule

@@ rtl/psfd_checker.sv @@
// ---------------------------------------------------------------------------
// psfd_checker: port-level checks for the frame deframer
// Watches the top-level ports and is bound to the top level below.
// ---------------------------------------------------------------------------
module psfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  result_kind_o,
  input logic [31:0] seq_number_o,
  input logic [31:0] frame_length_o,
  input logic [7:0]  data_byte_o,
  input logic [1:0]  body_part_o,
  input logic        last_body_o
);

  // A stalled result keeps its kind, sequence number, length and data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(seq_number_o) && $stable(frame_length_o) && $stable(data_byte_o))
    else $error("stalled result changed");

  // Only body items carry byte, part and last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != psfd_pkg::KIND_BODY |->
      data_byte_o == 8'd0 && body_part_o == psfd_pkg::PART_IV && last_body_o == 1'b0)
    else $error("non-body item with body fields set");

  // Body items are tagged with a defined part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == psfd_pkg::KIND_BODY |->
      body_part_o == psfd_pkg::PART_IV || body_part_o == psfd_pkg::PART_CIPHER ||
      body_part_o == psfd_pkg::PART_TAG)
    else $error("body item with undefined part");

  // With the result register empty the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while result register empty");

  // A header or length error never follows directly on a body byte not marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && result_kind_o == psfd_pkg::KIND_BODY && !last_body_o
      ##1 out_valid_o |-> result_kind_o == psfd_pkg::KIND_BODY)
    else $error("body cut short before its last byte");

endmodule

bind prefix_sync_frame_deframer psfd_checker u_psfd_checker (.*);
